// ===== sv/ctb_pkg.sv =====
// package for the charset translation builder
// opcodes, result status codes, sequencer states and the table port struct
// no dependencies
package ctb_pkg;

   localparam int TABLE_SIZE = 256;
   localparam logic [7:0] CONTROL_LIMIT = 8'd32;

   localparam logic [1:0] OP_CLEAR = 2'd0;
   localparam logic [1:0] OP_ADD   = 2'd1;
   localparam logic [1:0] OP_APPLY = 2'd2;
   localparam logic [1:0] OP_READ  = 2'd3;

   localparam logic [2:0] STAT_DONE     = 3'd0;
   localparam logic [2:0] STAT_NO_MATCH = 3'd1;
   localparam logic [2:0] STAT_RANGE    = 3'd2;
   localparam logic [2:0] STAT_FULL     = 3'd3;
   localparam logic [2:0] STAT_READ     = 3'd4;

   typedef enum logic [1:0] {
      S_IDLE,
      S_SCAN,
      S_TREAD,
      S_FINISH
   } state_type;

   // one access to the translation table per cycle
   typedef struct packed {
      logic       clr;
      logic       wr_en;
      logic       rd_en;
      logic [7:0] addr;
      logic [7:0] wr_data;
   } tbl_req_type;

endpackage

// ===== sv/ctb_tbl.sv =====
// translation table: 256 x 8 memory with per-entry valid bits
// an entry that is not valid reads as its index; control positions always do
// depends on ctb_pkg
module ctb_tbl (
   input  logic                clock,
   input  logic                reset,
   input  ctb_pkg::tbl_req_type tbl_req,
   output logic [7:0]          rd_data
);
   import ctb_pkg::*;

   logic [7:0]            mem [TABLE_SIZE];
   logic [TABLE_SIZE-1:0] valid_ff;
   logic [TABLE_SIZE-1:0] valid_in;
   logic [7:0]            q_ff;
   logic [7:0]            rd_addr_ff;
   logic                  rd_hit_ff;

   always_comb begin
      valid_in = valid_ff;
      if (tbl_req.clr) begin
         valid_in = '0;
      end else if (tbl_req.wr_en) begin
         valid_in[tbl_req.addr] = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem[tbl_req.addr] <= tbl_req.wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (tbl_req.rd_en) begin
         q_ff       <= mem[tbl_req.addr];
         rd_addr_ff <= tbl_req.addr;
         rd_hit_ff  <= valid_ff[tbl_req.addr];
      end
   end

   always_comb begin
      if (rd_addr_ff < CONTROL_LIMIT) begin
         rd_data = rd_addr_ff;
      end else if (rd_hit_ff) begin
         rd_data = q_ff;
      end else begin
         rd_data = rd_addr_ff;
      end
   end

`ifndef ASSERT_OFF
   a_clr_empties: assert property (@(posedge clock) disable iff (reset)
      tbl_req.clr |=> valid_ff == '0)
      else $error("table clear left valid entries");
   a_wr_marks: assert property (@(posedge clock) disable iff (reset)
      tbl_req.wr_en && !tbl_req.clr |=> valid_ff[$past(tbl_req.addr)])
      else $error("table write did not mark entry valid");
   a_ctrl_ident: assert property (@(posedge clock) disable iff (reset)
      tbl_req.rd_en && tbl_req.addr < CONTROL_LIMIT |=> rd_data == $past(tbl_req.addr))
      else $error("control position did not read as itself");
`endif

endmodule

// ===== sv/charset_translation_builder_unit.sv =====
// Charset translation builder. Items are taken one at a time: clear and add go
// straight to the finish state, read passes through a table-read state, and apply
// runs a match scan over the stored targets through the single read port of the
// target store, one entry a cycle. A one-item output register lets the next
// item start while a result waits. The table needs no clearing pass after reset.
// depends on ctb_pkg and ctb_tbl
module charset_translation_builder_unit #(
   parameter int TARGET_ENTRIES = 512
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_opcode,
   input  logic [15:0] req_font_position,
   input  logic [15:0] req_code_point,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [2:0]  rsp_status,
   output logic [7:0]  rsp_mapped_code
);
   import ctb_pkg::*;

   localparam int CNT_W = $clog2(TARGET_ENTRIES + 1);
   localparam int AW    = (TARGET_ENTRIES > 1) ? $clog2(TARGET_ENTRIES) : 1;
   localparam logic [CNT_W-1:0] FULL_COUNT = CNT_W'(TARGET_ENTRIES);

   // target store: position in [23:16], code point in [15:0]
   logic [23:0]    store_mem [TARGET_ENTRIES];
   logic [23:0]    store_q_ff;
   logic           store_we;
   logic [AW-1:0]  store_waddr;
   logic [23:0]    store_wdata;
   logic           store_re;
   logic [AW-1:0]  store_raddr;

   state_type      state_ff, state_in;
   logic [7:0]     pos_ff, pos_in;
   logic [15:0]    code_ff, code_in;
   logic [CNT_W-1:0] scan_idx_ff, scan_idx_in;
   logic           rd_pend_ff, rd_pend_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [2:0]     res_status_ff, res_status_in;
   logic [7:0]     res_mapped_ff, res_mapped_in;
   logic           rsp_valid_ff, rsp_valid_in;
   logic [2:0]     rsp_status_ff, rsp_status_in;
   logic [7:0]     rsp_mapped_ff, rsp_mapped_in;

   tbl_req_type    tbl_req;
   logic [7:0]     tbl_rd_data;
   logic           accept;
   logic           pos_range;
   logic           issue_ok;
   logic           hit;
   logic           out_free;

   ctb_tbl u_tbl (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

   assign req_stall       = (state_ff != S_IDLE);
   assign accept          = req_valid && (state_ff == S_IDLE);
   assign pos_range       = |req_font_position[15:8];
   assign issue_ok        = scan_idx_ff < count_ff;
   assign hit             = rd_pend_ff && (store_q_ff[15:0] == code_ff);
   assign out_free        = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_mapped_code = rsp_mapped_ff;

   always_comb begin
      state_in      = state_ff;
      pos_in        = pos_ff;
      code_in       = code_ff;
      scan_idx_in   = scan_idx_ff;
      rd_pend_in    = 1'b0;
      count_in      = count_ff;
      res_status_in = res_status_ff;
      res_mapped_in = res_mapped_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      rsp_status_in = rsp_status_ff;
      rsp_mapped_in = rsp_mapped_ff;
      store_we      = 1'b0;
      store_waddr   = count_ff[AW-1:0];
      store_wdata   = {req_font_position[7:0], req_code_point};
      store_re      = 1'b0;
      store_raddr   = scan_idx_ff[AW-1:0];
      tbl_req       = '0;
      tbl_req.addr  = req_font_position[7:0];

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               pos_in        = req_font_position[7:0];
               code_in       = req_code_point;
               res_status_in = STAT_DONE;
               res_mapped_in = 8'd0;
               state_in      = S_FINISH;
               unique case (req_opcode)
                  OP_CLEAR: begin
                     tbl_req.clr = 1'b1;
                     count_in    = '0;
                  end
                  OP_ADD: begin
                     if (pos_range) begin
                        res_status_in = STAT_RANGE;
                     end else if (count_ff >= FULL_COUNT) begin
                        res_status_in = STAT_FULL;
                     end else begin
                        store_we = 1'b1;
                        count_in = count_ff + 1'b1;
                     end
                  end
                  OP_APPLY: begin
                     if (pos_range) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        scan_idx_in = '0;
                        state_in    = S_SCAN;
                     end
                  end
                  OP_READ: begin
                     if (pos_range) begin
                        res_status_in = STAT_RANGE;
                     end else begin
                        tbl_req.rd_en = 1'b1;
                        state_in      = S_TREAD;
                     end
                  end
                  default: begin
                     res_status_in = STAT_DONE;
                  end
               endcase
            end
         end
         S_SCAN: begin
            // one store read issued per cycle, compared in the next cycle
            if (hit) begin
               tbl_req.wr_en   = 1'b1;
               tbl_req.addr    = pos_ff;
               tbl_req.wr_data = store_q_ff[23:16];
               res_status_in   = STAT_DONE;
               state_in        = S_FINISH;
            end else if (!issue_ok) begin
               res_status_in = STAT_NO_MATCH;
               state_in      = S_FINISH;
            end else begin
               store_re   = issue_ok;
               rd_pend_in = issue_ok;
               if (issue_ok) begin
                  scan_idx_in = scan_idx_ff + 1'b1;
               end
            end
         end
         S_TREAD: begin
            res_status_in = STAT_READ;
            res_mapped_in = tbl_rd_data;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = res_status_ff;
               rsp_mapped_in = res_mapped_ff;
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      pos_ff        <= pos_in;
      code_ff       <= code_in;
      scan_idx_ff   <= scan_idx_in;
      res_status_ff <= res_status_in;
      res_mapped_ff <= res_mapped_in;
      rsp_status_ff <= rsp_status_in;
      rsp_mapped_ff <= rsp_mapped_in;
   end

   always_ff @(posedge clock) begin
      if (store_we) begin
         store_mem[store_waddr] <= store_wdata;
      end
   end

   always_ff @(posedge clock) begin
      if (store_re) begin
         store_q_ff <= store_mem[store_raddr];
      end
   end

`ifndef ASSERT_OFF
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL_COUNT)
      else $error("target count beyond store depth");
   a_mapped_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid_ff && rsp_status_ff != STAT_READ |-> rsp_mapped_ff == 8'd0)
      else $error("nonzero mapped code on non-read result");
   a_clear_count: assert property (@(posedge clock) disable iff (reset)
      accept && req_opcode == OP_CLEAR |=> count_ff == '0)
      else $error("clear did not empty the target store");
   a_scan_in_store: assert property (@(posedge clock) disable iff (reset)
      store_re |-> scan_idx_ff < count_ff)
      else $error("scan read past stored targets");
`endif

endmodule
